// ===== hw/rtl/gra_pkg.sv =====
package gra_pkg;

  // The quotient of each lane's ceiling division is at most total_extra + 1.
  localparam int QUO_BITS   = 17;
  localparam int ITER_BITS  = 5;
  localparam int SHARE_BITS = 16;
  localparam int CELLS      = 3;

  typedef logic [1:0] cell_idx_t;

  typedef struct packed {
    logic                  done;
    logic [SHARE_BITS-1:0] share;
  } lane_res_t;

endpackage

// ===== hw/rtl/gra_lane.sv =====
module gra_lane #(
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [gra_pkg::SHARE_BITS-1:0]  total,
  input  logic [COUNT_BITS-1:0]           cnt,
  input  logic [COUNT_BITS+1:0]           sum,
  output gra_pkg::lane_res_t              res
);

  localparam int NUM_W = COUNT_BITS + gra_pkg::QUO_BITS;
  localparam int DVD_W = NUM_W + 1;
  localparam int SUM_W = COUNT_BITS + 2;
  localparam int QB    = gra_pkg::QUO_BITS;
  localparam logic [gra_pkg::ITER_BITS-1:0] ITER_LAST = gra_pkg::ITER_BITS'(QB - 1);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_LOAD = 4'b0010,
    L_DIV  = 4'b0100,
    L_DONE = 4'b1000
  } lane_state_t;

  lane_state_t                    state_r;
  logic [NUM_W-1:0]               num_r;
  logic [SUM_W-1:0]               sum_r;
  logic [SUM_W-1:0]               rem_r;
  logic [QB-1:0]                  quo_r;
  logic [gra_pkg::ITER_BITS-1:0]  iter_r;

  logic [QB-1:0]    total_p1;
  logic [DVD_W-1:0] dvd;
  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   diff;
  logic             ge;
  logic [QB-1:0]    quo_m1;

  assign total_p1 = QB'(total) + QB'(1);
  // Adding sum - 1 before dividing turns the floor into a ceiling.
  assign dvd      = DVD_W'(num_r) + DVD_W'(sum_r) - DVD_W'(1);
  assign trial    = {rem_r, quo_r[QB-1]};
  assign diff     = trial - {1'b0, sum_r};
  assign ge       = trial >= {1'b0, sum_r};
  assign quo_m1   = quo_r - QB'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else if (start) begin
      state_r <= L_LOAD;
    end else begin
      unique case (state_r)
        L_LOAD: state_r <= L_DIV;
        L_DIV: begin
          if (iter_r == ITER_LAST) state_r <= L_DONE;
        end
        default: state_r <= state_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= NUM_W'(total_p1) * NUM_W'(cnt);
      sum_r <= sum;
    end else if (state_r == L_LOAD) begin
      rem_r  <= SUM_W'(dvd[DVD_W-1:QB]);
      quo_r  <= dvd[QB-1:0];
      iter_r <= '0;
    end else if (state_r == L_DIV) begin
      rem_r  <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      quo_r  <= {quo_r[QB-2:0], ge};
      iter_r <= iter_r + gra_pkg::ITER_BITS'(1);
    end
  end

  assign res.done  = (state_r == L_DONE);
  assign res.share = (quo_r == '0) ? '0 : quo_m1[gra_pkg::SHARE_BITS-1:0];

endmodule

// ===== hw/rtl/gra_merge.sv =====
module gra_merge #(
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            ack,
  input  logic [gra_pkg::SHARE_BITS-1:0]  total,
  input  logic [COUNT_BITS-1:0]           cnt [gra_pkg::CELLS],
  input  logic                            sum_zero,
  input  gra_pkg::lane_res_t              lres [gra_pkg::CELLS],
  output logic                            done,
  output logic [gra_pkg::SHARE_BITS-1:0]  share [gra_pkg::CELLS]
);

  localparam int QB = gra_pkg::QUO_BITS;
  localparam int PW = COUNT_BITS + QB;
  localparam int GW = gra_pkg::SHARE_BITS + 2;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_MUL  = 4'b0010,
    M_SEL  = 4'b0100,
    M_FIN  = 4'b1000
  } merge_state_t;

  merge_state_t        state_r;
  logic [QB-1:0]       slots_r [gra_pkg::CELLS];
  logic [PW-1:0]       prod_r  [gra_pkg::CELLS][gra_pkg::CELLS];
  logic [1:0]          rem_r;
  logic                first_r;
  gra_pkg::cell_idx_t  cur_r;
  gra_pkg::cell_idx_t  nxt_r;

  gra_pkg::cell_idx_t  pb;
  gra_pkg::cell_idx_t  pr;
  gra_pkg::cell_idx_t  sel_cur;
  gra_pkg::cell_idx_t  sel_nxt;
  logic                reselect;
  logic [GW-1:0]       given;
  logic [GW-1:0]       left;

  // Cell x outranks cell y on a larger count/slots, ties to the higher index.
  function automatic logic outranks(input logic [PW-1:0] pxy, input logic [PW-1:0] pyx,
                                    input logic x_higher);
    return (pxy != pyx) ? (pxy > pyx) : x_higher;
  endfunction

  always_comb begin
    pb = 2'd0;
    if (outranks(prod_r[1][0], prod_r[0][1], 1'b1)) pb = 2'd1;
    if (outranks(prod_r[2][pb], prod_r[pb][2], 1'b1)) pb = 2'd2;
    pr = (pb == 2'd0) ? 2'd1 : 2'd0;
    for (int i = 0; i < gra_pkg::CELLS; i++) begin
      if (2'(i) != pb && outranks(prod_r[i][pr], prod_r[pr][i], 2'(i) > pr)) pr = 2'(i);
    end
  end

  assign reselect = first_r || (prod_r[cur_r][nxt_r] < prod_r[nxt_r][cur_r]);
  assign sel_cur  = reselect ? pb : cur_r;
  assign sel_nxt  = reselect ? pr : nxt_r;
  assign given    = GW'(lres[0].share) + GW'(lres[1].share) + GW'(lres[2].share);
  assign left     = GW'(total) - given;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
    end else begin
      unique case (state_r)
        M_IDLE: begin
          if (start) state_r <= sum_zero ? M_FIN : M_MUL;
        end
        M_MUL: state_r <= M_SEL;
        M_SEL: state_r <= (rem_r == 2'd0) ? M_FIN : M_MUL;
        M_FIN: begin
          if (ack) state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == M_IDLE && start) begin
      first_r <= 1'b1;
      if (sum_zero) begin
        slots_r[0] <= QB'(1);
        slots_r[1] <= QB'(1);
        slots_r[2] <= QB'(total) + QB'(1);
        rem_r      <= 2'd0;
      end else begin
        for (int i = 0; i < gra_pkg::CELLS; i++) slots_r[i] <= QB'(lres[i].share) + QB'(1);
        // The ceiling split leaves at most two units for the greedy pass.
        rem_r <= left[1:0];
      end
    end else if (state_r == M_MUL) begin
      for (int a = 0; a < gra_pkg::CELLS; a++) begin
        for (int b = 0; b < gra_pkg::CELLS; b++) begin
          prod_r[a][b] <= PW'(cnt[a]) * PW'(slots_r[b]);
        end
      end
    end else if (state_r == M_SEL) begin
      first_r <= 1'b0;
      cur_r   <= sel_cur;
      nxt_r   <= sel_nxt;
      if (rem_r != 2'd0) begin
        slots_r[sel_cur] <= slots_r[sel_cur] + QB'(1);
        rem_r            <= rem_r - 2'd1;
      end
    end
  end

  assign done = (state_r == M_FIN);

  always_comb begin
    for (int i = 0; i < gra_pkg::CELLS; i++) begin
      share[i] = gra_pkg::SHARE_BITS'(slots_r[i] - QB'(1));
    end
  end

endmodule

// ===== hw/rtl/greedy_ratio_apportionment.sv =====
// Splits in_total_extra units over three cells in proportion to the three counts,
// largest-averages style: each cell first gets ceil((total+1)*count/sum)-1, then the
// last one or two units go to the cell with the highest count/(share+1), ties to the
// higher index, but a tie with the runner-up keeps the cell that took the first unit;
// all counts zero sends everything to the third cell. One item is in work at a time.
// Three lanes run their ceiling divisions side by side in a 17-step restoring divider,
// after which the merging unit loads the shares and, unless all counts are zero, runs
// a multiply step and a select step for each leftover unit and once more for the final
// selection. The input is stalled until the result has entered the output register,
// so the next item can be accepted in the cycle after that. A finished result waits
// in the output register while the next item is accepted.
module greedy_ratio_apportionment #(
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [15:0]            in_total_extra,
  input  logic [COUNT_BITS-1:0]  in_count_first,
  input  logic [COUNT_BITS-1:0]  in_count_second,
  input  logic [COUNT_BITS-1:0]  in_count_third,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [15:0]            out_share_first,
  output logic [15:0]            out_share_second,
  output logic [15:0]            out_share_third
);

  localparam int SUM_W = COUNT_BITS + 2;

  logic                            busy_r;
  logic                            wait_r;
  logic [15:0]                     total_r;
  logic [COUNT_BITS-1:0]           cnt_r [gra_pkg::CELLS];
  logic                            sum_zero_r;
  logic                            out_valid_r;
  logic [15:0]                     out_first_r;
  logic [15:0]                     out_second_r;
  logic [15:0]                     out_third_r;

  logic                            accept;
  logic                            out_free;
  logic                            lanes_done;
  logic                            merge_start;
  logic                            merge_done;
  logic [SUM_W-1:0]                sum;
  logic [COUNT_BITS-1:0]           cnt_in [gra_pkg::CELLS];
  gra_pkg::lane_res_t              lres [gra_pkg::CELLS];
  logic [gra_pkg::SHARE_BITS-1:0]  share [gra_pkg::CELLS];

  assign accept   = in_valid && !busy_r;
  assign in_stall = busy_r;
  assign out_free = !out_valid_r || !out_stall;

  assign cnt_in[0] = in_count_first;
  assign cnt_in[1] = in_count_second;
  assign cnt_in[2] = in_count_third;
  assign sum = SUM_W'(in_count_first) + SUM_W'(in_count_second) + SUM_W'(in_count_third);

  for (genvar g = 0; g < gra_pkg::CELLS; g++) begin : g_lane
    gra_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (accept),
      .total (in_total_extra),
      .cnt   (cnt_in[g]),
      .sum   (sum),
      .res   (lres[g])
    );
  end

  assign lanes_done  = lres[0].done && lres[1].done && lres[2].done;
  assign merge_start = wait_r && lanes_done;

  gra_merge #(.COUNT_BITS(COUNT_BITS)) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (merge_start),
    .ack      (out_free),
    .total    (total_r),
    .cnt      (cnt_r),
    .sum_zero (sum_zero_r),
    .lres     (lres),
    .done     (merge_done),
    .share    (share)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
        wait_r <= 1'b1;
      end else if (merge_start) begin
        wait_r <= 1'b0;
      end
      if (merge_done && out_free) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      total_r    <= in_total_extra;
      cnt_r      <= cnt_in;
      sum_zero_r <= (sum == '0);
    end
    if (merge_done && out_free) begin
      out_first_r  <= share[0];
      out_second_r <= share[1];
      out_third_r  <= share[2];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_share_first  = out_first_r;
  assign out_share_second = out_second_r;
  assign out_share_third  = out_third_r;

endmodule
